// ----- src/lcsa_pkg.sv -----
// Shared types, constants and helpers for the life cell step engine.
// No dependencies; imported by lcsa_store and life_cell_step_with_age_core.
package lcsa_pkg;

  // Default grid size
  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;

  // Field widths
  localparam int COORD_W = 6;
  localparam int AGE_W   = 8;
  localparam int CNT_W   = 4;

  // Age limits and register reset
  localparam logic [AGE_W-1:0] AGE_SAT     = 8'd255;
  localparam logic [AGE_W-1:0] MAX_AGE_RST = 8'd100;

  // Register index (selected by paddr[2])
  localparam logic REG_MAX_AGE = 1'b0;

  // Operation codes carried in s_tuser
  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_EVAL    = 2'd1,
    FUNC_ADVANCE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  // Neighborhood scan: steps 0..8 walk the 3x3 window row by row
  localparam logic [3:0] STEP_CENTER = 4'd4;
  localparam logic [3:0] STEP_LAST   = 4'd8;

  // Write controls from the sequencer to the cell store
  typedef struct packed {
    logic             even_we;
    logic             odd_we;
    logic             age_we;
    logic             bit_data;
    logic [AGE_W-1:0] age_data;
  } wr_ctl_t;

  // Column of the window (0 left, 1 middle, 2 right) for a scan step
  function automatic logic [1:0] step_col(input logic [3:0] s);
    logic [1:0] c;
    case (s)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  // Row of the window (0 above, 1 same row, 2 below) for a scan step
  function automatic logic [1:0] step_row(input logic [3:0] s);
    logic [1:0] r;
    case (s)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

endpackage

// ----- src/lcsa_store.sv -----
// Cell store: the two ping-pong bit planes and the per-cell age memory.
// Depends on lcsa_pkg (wr_ctl_t). Synchronous reads, one write port each.
module lcsa_store #(
  parameter int GRID_WIDTH  = lcsa_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = lcsa_pkg::GRID_HEIGHT_DEF
) (
  input  logic                                           clk,
  input  lcsa_pkg::wr_ctl_t                              wr,
  input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]      wr_addr,
  input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]      rd_addr,
  input  logic [$clog2(GRID_WIDTH*GRID_HEIGHT)-1:0]      age_addr,
  output logic                                           even_q,
  output logic                                           odd_q,
  output logic [lcsa_pkg::AGE_W-1:0]                     age_q
);
  import lcsa_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;

  logic             plane_even [CELLS];
  logic             plane_odd  [CELLS];
  logic [AGE_W-1:0] cell_ages  [CELLS];

  // Even plane
  always_ff @(posedge clk) begin
    if (wr.even_we) begin
      plane_even[wr_addr] <= wr.bit_data;
    end
    even_q <= plane_even[rd_addr];
  end

  // Odd plane
  always_ff @(posedge clk) begin
    if (wr.odd_we) begin
      plane_odd[wr_addr] <= wr.bit_data;
    end
    odd_q <= plane_odd[rd_addr];
  end

  // Ages
  always_ff @(posedge clk) begin
    if (wr.age_we) begin
      cell_ages[wr_addr] <= wr.age_data;
    end
    age_q <= cell_ages[age_addr];
  end

endmodule

// ----- src/life_cell_step_with_age_core.sv -----
// Top level of the B3/S23 life cell engine with per-cell age.
// Depends on lcsa_pkg and lcsa_store.
//
// Each transfer on the s_ side carries one operation (load a cell, evaluate a
// cell, advance the generation) and yields exactly one result transfer on the
// m_ side. After reset the block sweeps the planes and the age memory to zero,
// one cell per cycle, over all GRID_WIDTH*GRID_HEIGHT cells (4096 at the
// default size); s_tready stays low meanwhile, while APB writes are taken as
// usual. Items are handled one at a time. An evaluation reads the nine cells
// of the 3x3 window one per cycle through the single plane read port, sums
// them in one shared counter, then applies the rule, writes back and hands
// the result to the output register (ST_TALLY, ST_WRITE, ST_RESULT). A load
// runs ST_SCAN, ST_TALLY, ST_WRITE and ST_RESULT; an advance, an unused code
// or an off-grid address goes straight to ST_RESULT. The output register lets
// the next item be accepted while a result still waits for m_tready.
module life_cell_step_with_age_core #(
  parameter int GRID_WIDTH  = lcsa_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = lcsa_pkg::GRID_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] func
  input  logic [15:0] s_tdata,   // [5:0] cell_x, [11:6] cell_y, [12] load_value
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [0] alive_next, [4:1] neighbour_count,
                                 // [12:5] cell_age_out, [13] retire
);
  import lcsa_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [5:0] {
    ST_CLEAR  = 6'b000001,
    ST_IDLE   = 6'b000010,
    ST_SCAN   = 6'b000100,
    ST_TALLY  = 6'b001000,
    ST_WRITE  = 6'b010000,
    ST_RESULT = 6'b100000
  } state_t;

  state_t             state;
  logic               parity;
  logic [AGE_W-1:0]   max_age;
  logic [AW-1:0]      clr_addr;

  // Latched item
  func_t              op;
  logic [COORD_W-1:0] cx;
  logic [COORD_W-1:0] cy;
  logic               lv;
  logic [AW-1:0]      center;

  // Scan state
  logic [3:0]         step;
  logic [3:0]         step_q;
  logic               nb_ok_q;
  logic               live_q;
  logic [CNT_W-1:0]   cnt;
  logic               alive;

  // Result held until the output register is free
  logic               res_alive;
  logic [CNT_W-1:0]   res_cnt;
  logic [AGE_W-1:0]   res_age;
  logic               res_retire;
  logic               res_load;

  // Store interface
  wr_ctl_t            wr;
  logic [AW-1:0]      wr_addr;
  logic [AW-1:0]      rd_addr;
  logic               even_q;
  logic               odd_q;
  logic [AGE_W-1:0]   age_q;

  // Input decode
  logic [COORD_W-1:0] in_x;
  logic [COORD_W-1:0] in_y;
  logic               in_lv;
  func_t              in_func;
  logic               in_on_grid;
  logic [AW-1:0]      in_center;

  // Neighbor address and tally
  logic [1:0]         col;
  logic [1:0]         row;
  logic               nb_ok;
  logic               cur_bit;
  logic [CNT_W-1:0]   tally_cnt;
  logic               alive_now;
  logic [AGE_W-1:0]   age_inc;
  logic               rule_alive;
  logic [AGE_W-1:0]   rule_age;

  assign s_tready = (state == ST_IDLE);
  assign pready   = 1'b1;
  assign prdata   = (paddr[2] == REG_MAX_AGE) ? {24'b0, max_age} : 32'b0;

  assign in_x       = s_tdata[5:0];
  assign in_y       = s_tdata[11:6];
  assign in_lv      = s_tdata[12];
  assign in_func    = func_t'(s_tuser);
  assign in_on_grid = (int'(in_x) < GRID_WIDTH) && (int'(in_y) < GRID_HEIGHT);
  assign in_center  = AW'(int'(in_y) * GRID_WIDTH + int'(in_x));

  // Window position of the current step; cells past an edge count as dead
  assign col   = step_col(step);
  assign row   = step_row(step);
  assign nb_ok = !(col == 2'd0 && cx == '0) && !(col == 2'd2 && int'(cx) == GRID_WIDTH - 1) &&
                 !(row == 2'd0 && cy == '0) && !(row == 2'd2 && int'(cy) == GRID_HEIGHT - 1);
  assign rd_addr = center + AW'((int'(row) - 1) * GRID_WIDTH + int'(col) - 1);

  // Shared counter: adds the plane bit read in the previous cycle
  assign cur_bit   = parity ? odd_q : even_q;
  assign tally_cnt = cnt + {3'b0, live_q && nb_ok_q && (step_q != STEP_CENTER) && cur_bit};
  assign alive_now = (live_q && step_q == STEP_CENTER) ? cur_bit : alive;

  // B3/S23 rule with saturating age
  assign age_inc = (age_q == AGE_SAT) ? AGE_SAT : age_q + 8'd1;
  always_comb begin
    if (tally_cnt == 4'd2) begin
      rule_alive = alive_now;
      rule_age   = age_inc;
    end else if (tally_cnt == 4'd3) begin
      rule_alive = 1'b1;
      rule_age   = alive_now ? age_inc : '0;
    end else begin
      rule_alive = 1'b0;
      rule_age   = alive_now ? '0 : age_inc;
    end
  end

  // Output register takes a result when it is empty or draining
  assign res_load = (state == ST_RESULT) && (!m_tvalid || m_tready);

  // Store write control
  always_comb begin
    wr      = '0;
    wr_addr = center;
    case (state)
      ST_CLEAR: begin
        wr.even_we = 1'b1;
        wr.odd_we  = 1'b1;
        wr.age_we  = 1'b1;
        wr_addr    = clr_addr;
      end
      ST_WRITE: begin
        if (op == FUNC_LOAD) begin
          wr.even_we  = !parity;
          wr.odd_we   = parity;
          wr.bit_data = lv;
        end else begin
          wr.even_we  = parity;
          wr.odd_we   = !parity;
          wr.bit_data = res_alive;
          wr.age_we   = 1'b1;
          wr.age_data = res_age;
        end
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  lcsa_store #(
    .GRID_WIDTH  (GRID_WIDTH),
    .GRID_HEIGHT (GRID_HEIGHT)
  ) u_store (
    .clk      (clk),
    .wr       (wr),
    .wr_addr  (wr_addr),
    .rd_addr  (rd_addr),
    .age_addr (center),
    .even_q   (even_q),
    .odd_q    (odd_q),
    .age_q    (age_q)
  );

  // Scan pipeline tags, aligned with the registered read data
  always_ff @(posedge clk) begin
    live_q  <= (state == ST_SCAN);
    step_q  <= step;
    nb_ok_q <= nb_ok;
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      parity   <= 1'b0;
      max_age  <= MAX_AGE_RST;
      m_tvalid <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_AGE) begin
        max_age <= pwdata[7:0];
      end
      // Output valid: set on a new result, cleared by a transfer
      if (res_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_tvalid) begin
            op         <= in_func;
            cx         <= in_x;
            cy         <= in_y;
            lv         <= in_lv;
            center     <= in_center;
            step       <= '0;
            cnt        <= '0;
            alive      <= 1'b0;
            res_alive  <= 1'b0;
            res_cnt    <= '0;
            res_age    <= '0;
            res_retire <= 1'b0;
            if (in_func == FUNC_ADVANCE) begin
              parity <= ~parity;
              state  <= ST_RESULT;
            end else if ((in_func == FUNC_LOAD || in_func == FUNC_EVAL) && in_on_grid) begin
              state <= ST_SCAN;
            end else begin
              state <= ST_RESULT;
            end
          end
        end
        ST_SCAN: begin
          cnt   <= tally_cnt;
          alive <= alive_now;
          step  <= step + 4'd1;
          if (op == FUNC_LOAD || step == STEP_LAST) begin
            state <= ST_TALLY;
          end
        end
        ST_TALLY: begin
          if (op == FUNC_LOAD) begin
            res_alive  <= lv;
            res_cnt    <= '0;
            res_age    <= age_q;
            res_retire <= 1'b0;
          end else begin
            res_alive  <= rule_alive;
            res_cnt    <= tally_cnt;
            res_age    <= rule_age;
            res_retire <= (rule_age == max_age);
          end
          state <= ST_WRITE;
        end
        ST_WRITE: begin
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (res_load) begin
            m_tdata <= {2'b0, res_retire, res_age, res_cnt, res_alive};
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/lcsa_check.sv -----
// Port-level checks for life_cell_step_with_age_core, bound to the top level.
// No dependencies beyond the top level's ports.
module lcsa_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  // Reset starts the clearing sweep with nothing pending
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("ready or result valid right after reset");

  // One item at a time: no accept in the cycle after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

  // At most eight neighbors
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[4:1] <= 4'd8)
    else $error("neighbor count above eight");

  // Three neighbors always leave the cell alive
  a_three_alive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[4:1] == 4'd3 |-> m_tdata[0])
    else $error("dead result with three neighbors");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind life_cell_step_with_age_core lcsa_check u_lcsa_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ----- tb/lcsa_result_checker.sv -----
`timescale 1ns / 100ps
// Result checker for life_cell_step_with_age_core: tracks both bit planes, the
// age store and max_age from the observed transfers and compares every result.
// Depends on lcsa_pkg; instantiated by life_cell_step_with_age_core_test.
module lcsa_result_checker (
  input  logic        clk,
  input  logic        rst,
  // APB port, observed only
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  // operation stream
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [1:0]  s_tuser,   // [1:0] func
  input  logic [15:0] s_tdata,   // [5:0] cell_x, [11:6] cell_y, [12] load_value
  // result stream
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // [0] alive_next, [4:1] neighbour_count,
                                 // [12:5] cell_age_out, [13] retire
  output int          error_count,
  output int          outstanding,
  output int          results_checked,
  output int          evals_seen,
  output int          retires_seen
);
  import lcsa_pkg::*;

  localparam int CELLS = GRID_WIDTH_DEF * GRID_HEIGHT_DEF;

  // Same bit order as m_tdata[13:0]
  typedef struct packed {
    logic             retire;
    logic [AGE_W-1:0] age;
    logic [CNT_W-1:0] count;
    logic             alive;
  } cell_result_t;

  logic             plane_even [CELLS];
  logic             plane_odd  [CELLS];
  logic [AGE_W-1:0] age_mem    [CELLS];
  logic             odd_current;
  logic [AGE_W-1:0] age_limit;
  cell_result_t     expected_q [$];

  // Cell of the current plane; off-grid cells read as dead
  function automatic logic live_at(input int x, input int y);
    if (x < 0 || y < 0 || x >= GRID_WIDTH_DEF || y >= GRID_HEIGHT_DEF)
      return 1'b0;
    return odd_current ? plane_odd[y * GRID_WIDTH_DEF + x]
                       : plane_even[y * GRID_WIDTH_DEF + x];
  endfunction

  function automatic logic [AGE_W-1:0] age_bump(input logic [AGE_W-1:0] a);
    return (a == AGE_SAT) ? AGE_SAT : a + 1'b1;
  endfunction

  // Apply one operation to the tracked grid and queue its result
  task automatic predict_step(input func_t f, input int x, input int y, input logic lv);
    cell_result_t     r;
    int               idx;
    int               n;
    logic             alive;
    logic             nv;
    logic [AGE_W-1:0] age;
    r = '0;
    if (f == FUNC_ADVANCE) begin
      odd_current = ~odd_current;
    end else if ((f == FUNC_LOAD || f == FUNC_EVAL) &&
                 x < GRID_WIDTH_DEF && y < GRID_HEIGHT_DEF) begin
      idx = y * GRID_WIDTH_DEF + x;
      if (f == FUNC_LOAD) begin
        if (odd_current) plane_odd[idx] = lv;
        else plane_even[idx] = lv;
        r.alive = lv;
        r.age   = age_mem[idx];
      end else begin
        n = 0;
        for (int dy = -1; dy <= 1; dy++)
          for (int dx = -1; dx <= 1; dx++)
            if (dx != 0 || dy != 0) n += live_at(x + dx, y + dy);
        alive = live_at(x, y);
        age   = age_mem[idx];
        // B3/S23 with age: survivors and still-dead cells age, births and deaths restart
        if (n == 2) begin
          nv  = alive;
          age = age_bump(age);
        end else if (n == 3) begin
          nv  = 1'b1;
          age = alive ? age_bump(age) : '0;
        end else begin
          nv  = 1'b0;
          age = alive ? '0 : age_bump(age);
        end
        if (odd_current) plane_even[idx] = nv;
        else plane_odd[idx] = nv;
        age_mem[idx] = age;
        r.alive  = nv;
        r.count  = CNT_W'(n);
        r.age    = age;
        r.retire = (age == age_limit);
        evals_seen++;
      end
    end
    expected_q = {expected_q, r};
  endtask

  always @(posedge clk) begin : watch
    cell_result_t got;
    cell_result_t want;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        plane_even[i] = 1'b0;
        plane_odd[i]  = 1'b0;
        age_mem[i]    = '0;
      end
      odd_current = 1'b0;
      age_limit   = MAX_AGE_RST;
      expected_q.delete();
      error_count     = 0;
      results_checked = 0;
      evals_seen      = 0;
      retires_seen    = 0;
    end else begin
      // register write
      if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_AGE)
        age_limit = pwdata[AGE_W-1:0];
      // result transfer
      if (m_tvalid && m_tready) begin
        got = cell_result_t'(m_tdata[13:0]);
        if (expected_q.size() == 0) begin
          $error("result transfer with no operation pending: tdata %h", m_tdata);
          error_count++;
        end else begin
          want = expected_q.pop_front();
          if (got.alive !== want.alive) begin
            $error("alive_next: expected %0d, actual %0d", want.alive, got.alive);
            error_count++;
          end
          if (got.count !== want.count) begin
            $error("neighbour_count: expected %0d, actual %0d", want.count, got.count);
            error_count++;
          end
          if (got.age !== want.age) begin
            $error("cell_age_out: expected %0d, actual %0d", want.age, got.age);
            error_count++;
          end
          if (got.retire !== want.retire) begin
            $error("retire: expected %0d, actual %0d", want.retire, got.retire);
            error_count++;
          end
          results_checked++;
          if (want.retire) retires_seen++;
        end
      end
      // operation transfer
      if (s_tvalid && s_tready)
        predict_step(func_t'(s_tuser), s_tdata[5:0], s_tdata[11:6], s_tdata[12]);
    end
    outstanding = expected_q.size();
  end

endmodule

// ----- tb/life_cell_step_with_age_core_test.sv -----
`timescale 1ns / 100ps
// Top of the life cell engine testbench: clock, reset, APB writes, operation
// stimulus and output back-pressure. Depends on lcsa_pkg, the block under
// test and lcsa_result_checker, which does the prediction and comparison.
module life_cell_step_with_age_core_test;
  import lcsa_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [1:0]  s_tuser = '0;   // [1:0] func
  logic [15:0] s_tdata = '0;   // [5:0] cell_x, [11:6] cell_y, [12] load_value
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [0] alive_next, [4:1] neighbour_count,
                               // [12:5] cell_age_out, [13] retire

  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic hold_arm = 1'b0;
  logic hold_used = 1'b0;
  int   hold_left = 0;
  int   items_sent = 0;
  int   cycle_count = 0;

  int error_count;
  int outstanding;
  int results_checked;
  int evals_seen;
  int retires_seen;

  life_cell_step_with_age_core dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  lcsa_result_checker u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .error_count(error_count), .outstanding(outstanding),
    .results_checked(results_checked), .evals_seen(evals_seen),
    .retires_seen(retires_seen)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: random stalls plus one long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_arm && !hold_used) begin
      hold_used <= 1'b1;
      hold_left <= HOLD_CYCLES;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic write_max_age(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_MAX_AGE, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // One operation transfer, with an optional idle gap in front
  task automatic push_item(input func_t f, input logic [5:0] x, input logic [5:0] y,
                           input logic lv);
    int gap;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= f;
    s_tdata  <= {3'b000, lv, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // Stop offering and wait until every result is back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    @(posedge clk);
  endtask

  // Mostly loads and evaluations clustered in a 5x5 window that moves now and
  // then (often to an edge or corner), plus generation steps and scattered noise
  task automatic random_burst(input int count);
    int    ox;
    int    oy;
    int    pick;
    func_t f;
    ox = 0;
    oy = 0;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 4))
          0: begin ox = 0; oy = 0; end
          1: begin ox = 59; oy = 59; end
          2: begin ox = 0; oy = $urandom_range(0, 59); end
          3: begin ox = $urandom_range(0, 59); oy = 59; end
          default: begin ox = $urandom_range(0, 59); oy = $urandom_range(0, 59); end
        endcase
      end
      pick = $urandom_range(0, 99);
      if (pick < 30)
        push_item(FUNC_LOAD, 6'(ox + $urandom_range(0, 4)), 6'(oy + $urandom_range(0, 4)),
                  1'($urandom_range(0, 1)));
      else if (pick < 80)
        push_item(FUNC_EVAL, 6'(ox + $urandom_range(0, 4)), 6'(oy + $urandom_range(0, 4)),
                  1'($urandom_range(0, 1)));
      else if (pick < 88)
        push_item(FUNC_ADVANCE, 6'($urandom), 6'($urandom), 1'($urandom));
      else if (pick < 92)
        push_item(FUNC_NONE, 6'($urandom), 6'($urandom), 1'($urandom));
      else begin
        f = ($urandom_range(0, 1) != 0) ? FUNC_EVAL : FUNC_LOAD;
        push_item(f, 6'($urandom), 6'($urandom), 1'($urandom));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_max_age(8'd1);

    // Directed: corners, a row of three, a fully surrounded cell, step and unused code
    push_item(FUNC_LOAD, 6'd0, 6'd0, 1'b1);
    push_item(FUNC_LOAD, 6'd63, 6'd63, 1'b1);
    push_item(FUNC_LOAD, 6'd63, 6'd0, 1'b1);
    push_item(FUNC_LOAD, 6'd0, 6'd63, 1'b1);
    push_item(FUNC_EVAL, 6'd0, 6'd0, 1'b0);
    push_item(FUNC_EVAL, 6'd63, 6'd63, 1'b0);
    push_item(FUNC_LOAD, 6'd10, 6'd10, 1'b1);
    push_item(FUNC_LOAD, 6'd11, 6'd10, 1'b1);
    push_item(FUNC_LOAD, 6'd12, 6'd10, 1'b1);
    push_item(FUNC_EVAL, 6'd11, 6'd10, 1'b0);   // two neighbours: survives
    push_item(FUNC_EVAL, 6'd11, 6'd9, 1'b0);    // three neighbours: born
    push_item(FUNC_EVAL, 6'd10, 6'd10, 1'b0);   // one neighbour: dies
    push_item(FUNC_EVAL, 6'd30, 6'd30, 1'b0);   // isolated dead cell ages to max_age
    for (int dy = -1; dy <= 1; dy++)
      for (int dx = -1; dx <= 1; dx++)
        if (dx != 0 || dy != 0) push_item(FUNC_LOAD, 6'(20 + dx), 6'(20 + dy), 1'b1);
    push_item(FUNC_EVAL, 6'd20, 6'd20, 1'b0);   // eight neighbours
    push_item(FUNC_ADVANCE, 6'd63, 6'd63, 1'b1);
    push_item(FUNC_EVAL, 6'd11, 6'd9, 1'b0);
    push_item(FUNC_NONE, 6'd63, 6'd63, 1'b1);

    // Age saturation: one isolated cell evaluated past 255
    drain_results();
    write_max_age(AGE_SAT);
    for (int i = 0; i < 260; i++) push_item(FUNC_EVAL, 6'd63, 6'd32, 1'b0);

    // Random phases with different idling and max_age
    for (int phase = 0; phase < 4; phase++) begin
      drain_results();
      case (phase)
        0: begin
          send_idle_pct <= 0;
          stall_pct     <= 0;
          hold_arm      <= 1'b1;
          write_max_age(8'd3);
        end
        1: begin
          send_idle_pct <= 53;
          stall_pct     <= 0;
          write_max_age(8'($urandom_range(1, 255)));
        end
        2: begin
          send_idle_pct <= 0;
          stall_pct     <= 53;
          write_max_age(8'd1);
        end
        default: begin
          send_idle_pct <= 9;
          stall_pct     <= 9;
          write_max_age(8'd2);
        end
      endcase
      random_burst(240);
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("Covered %0d operations: %0d evaluations (%0d flagged for retire), %0d results checked",
             items_sent, evals_seen, retires_seen, results_checked);
    $display("Edges, corners, age saturation, stalls and a long output hold-off; max_age 1..255");
    if (error_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
